// ===== hdl/b64_pkg.sv =====
// ----------------------------------------------------------------------------
// b64_pkg
// shared types, codes and character tables of the base64 stream codec
// ----------------------------------------------------------------------------
package b64_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_URL_ALPHABET = 1'b1;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] CH_PAD = 8'h3D;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ENC = 2'd0;
  localparam kind_t KIND_DEC = 2'd1;
  localparam kind_t KIND_ERR = 2'd2;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  count;
    logic [2:0]  nsym;
    logic        last;
    logic [23:0] trip;
  } job_t;

  // sextet of a character of either alphabet, bit 6 set when none
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    case (c) inside
      [8'h41:8'h5A]: v = 7'(c - 8'd65);
      [8'h61:8'h7A]: v = 7'(c - 8'd71);
      [8'h30:8'h39]: v = 7'(c + 8'd4);
      8'h2B, 8'h2D:  v = 7'd62;
      8'h2F, 8'h5F:  v = 7'd63;
      default:       v = 7'd64;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] enc_char(input logic [5:0] s, input logic url);
    logic [7:0] c;
    case (s) inside
      [6'd0:6'd25]:  c = 8'(8'd65 + {2'b00, s});
      [6'd26:6'd51]: c = 8'(8'd71 + {2'b00, s});
      [6'd52:6'd61]: c = 8'({2'b00, s} - 8'd4);
      6'd62:         c = url ? 8'h2D : 8'h2B;
      default:       c = url ? 8'h5F : 8'h2F;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/b64_in_if.sv =====
// ----------------------------------------------------------------------------
// b64_in_if
// input item channel: one byte with a last mark
// ----------------------------------------------------------------------------
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_in;

  modport source (output valid, output in_byte, output last_in, input ready);
  modport sink (input valid, input in_byte, input last_in, output ready);
endinterface

// ===== hdl/b64_out_if.sv =====
// ----------------------------------------------------------------------------
// b64_out_if
// result item channel: one byte, last mark and error flag
// ----------------------------------------------------------------------------
interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_out;
  logic       error;

  modport source (output valid, output out_byte, output last_out, output error,
                  input ready);
  modport sink (input valid, input out_byte, input last_out, input error,
                output ready);
endinterface

// ===== hdl/b64_front.sv =====
// ----------------------------------------------------------------------------
// b64_front
// accepts items, gathers groups, checks decode syntax and queues jobs
// ----------------------------------------------------------------------------
module b64_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [b64_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [b64_pkg::CFG_DATA_W-1:0]      cfg_data,
  b64_in_if.sink                              stream,
  input  logic                                q_full,
  output logic                                push,
  output b64_pkg::job_t                       job,
  output logic                                url_alphabet
);

  logic        direction;
  logic [17:0] group_bits, group_bits_next;
  logic [1:0]  group_pos, group_pos_next;
  logic [1:0]  pad_count, pad_count_next;
  logic        bad_seen, bad_seen_next;
  logic        accept;
  logic [6:0]  v;
  logic [5:0]  vv;
  logic [1:0]  pad_n;
  logic        bad_n;
  logic [7:0]  b;
  logic        last;

  assign stream.ready = !q_full;
  assign accept = stream.valid && stream.ready;
  assign b = stream.in_byte;
  assign last = stream.last_in;
  assign v = b64_pkg::sextet_of(b);

  always_comb begin
    group_bits_next = group_bits;
    group_pos_next = group_pos;
    pad_count_next = pad_count;
    bad_seen_next = bad_seen;
    push = 1'b0;
    job.kind = b64_pkg::KIND_ERR;
    job.count = 3'd1;
    job.nsym = 3'd0;
    job.last = 1'b1;
    job.trip = '0;
    vv = v[5:0];
    pad_n = pad_count;
    bad_n = bad_seen;
    if (direction == b64_pkg::DIR_ENCODE) begin
      if (group_pos < 2'd2 && !last) begin
        group_bits_next = {group_bits[9:0], b};
        group_pos_next = 2'(group_pos + 2'd1);
      end else begin
        push = 1'b1;
        job.kind = b64_pkg::KIND_ENC;
        job.count = 3'd4;
        job.last = last;
        if (group_pos >= 2'd2) begin
          job.trip = {group_bits[15:0], b};
          job.nsym = 3'd4;
        end else if (group_pos == 2'd1) begin
          job.trip = {group_bits[7:0], b, 8'h00};
          job.nsym = 3'd3;
        end else begin
          job.trip = {b, 16'h0000};
          job.nsym = 3'd2;
        end
        group_bits_next = '0;
        group_pos_next = '0;
      end
    end else begin
      if (!bad_seen) begin
        if (b == b64_pkg::CH_PAD) begin
          if (group_pos < 2'd2) begin
            bad_n = 1'b1;
          end else begin
            pad_n = 2'(pad_count + 2'd1);
            vv = '0;
          end
        end else if (v[6] || pad_count != 2'd0) begin
          bad_n = 1'b1;
        end
      end
      if (bad_n) begin
        bad_seen_next = 1'b1;
        if (last) begin
          push = 1'b1;
          group_bits_next = '0;
          group_pos_next = '0;
          pad_count_next = '0;
          bad_seen_next = 1'b0;
        end
      end else if (group_pos < 2'd3) begin
        group_bits_next = {group_bits[11:0], vv};
        group_pos_next = 2'(group_pos + 2'd1);
        pad_count_next = pad_n;
        if (last) begin
          push = 1'b1;
          group_bits_next = '0;
          group_pos_next = '0;
          pad_count_next = '0;
        end
      end else begin
        group_bits_next = '0;
        group_pos_next = '0;
        pad_count_next = '0;
        if (pad_n != 2'd0 && !last) begin
          bad_seen_next = 1'b1;
        end else begin
          push = 1'b1;
          job.kind = b64_pkg::KIND_DEC;
          job.count = 3'(3'd3 - {1'b0, pad_n});
          job.last = last;
          job.trip = {group_bits, vv};
        end
      end
    end
    if (!accept) begin
      push = 1'b0;
      group_bits_next = group_bits;
      group_pos_next = group_pos;
      pad_count_next = pad_count;
      bad_seen_next = bad_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= b64_pkg::DIR_ENCODE;
      url_alphabet <= 1'b0;
      group_bits <= '0;
      group_pos <= '0;
      pad_count <= '0;
      bad_seen <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == b64_pkg::REG_DIRECTION) begin
        direction <= cfg_data[0];
        group_bits <= '0;
        group_pos <= '0;
        pad_count <= '0;
        bad_seen <= 1'b0;
      end else begin
        url_alphabet <= cfg_data[0];
      end
    end else begin
      group_bits <= group_bits_next;
      group_pos <= group_pos_next;
      pad_count <= pad_count_next;
      bad_seen <= bad_seen_next;
    end
  end

endmodule

// ===== hdl/b64_queue.sv =====
// ----------------------------------------------------------------------------
// b64_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module b64_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  b64_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output b64_pkg::job_t head
);

  b64_pkg::job_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;

  assign full = cnt == 2'd2;
  assign not_empty = cnt != 2'd0;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        cnt <= 2'(cnt + 2'd1);
      end else if (pop && !push) begin
        cnt <= 2'(cnt - 2'd1);
      end
    end
  end

endmodule

// ===== hdl/b64_back.sv =====
// ----------------------------------------------------------------------------
// b64_back
// expands queued jobs into result items through an output register
// ----------------------------------------------------------------------------
module b64_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          url_alphabet,
  input  logic          q_not_empty,
  input  b64_pkg::job_t q_head,
  output logic          pop,
  b64_out_if.source     result
);

  b64_pkg::job_t cur;
  logic          cur_valid;
  logic [1:0]    k;
  logic          step;
  logic          finish;
  logic [5:0]    sextet;
  logic [7:0]    dec_byte;
  logic [7:0]    item_byte;
  logic          item_last;
  logic          item_err;

  assign step = cur_valid && (!result.valid || result.ready);
  assign finish = step && ({1'b0, k} == 3'(cur.count - 3'd1));
  assign pop = q_not_empty && (!cur_valid || finish);

  always_comb begin
    case (k)
      2'd0:    sextet = cur.trip[23:18];
      2'd1:    sextet = cur.trip[17:12];
      2'd2:    sextet = cur.trip[11:6];
      default: sextet = cur.trip[5:0];
    endcase
    case (k)
      2'd0:    dec_byte = cur.trip[23:16];
      2'd1:    dec_byte = cur.trip[15:8];
      default: dec_byte = cur.trip[7:0];
    endcase
    case (cur.kind)
      b64_pkg::KIND_ENC: begin
        item_byte = ({1'b0, k} < cur.nsym) ? b64_pkg::enc_char(sextet, url_alphabet)
                                           : b64_pkg::CH_PAD;
        item_err = 1'b0;
      end
      b64_pkg::KIND_DEC: begin
        item_byte = dec_byte;
        item_err = 1'b0;
      end
      default: begin
        item_byte = 8'h00;
        item_err = 1'b1;
      end
    endcase
    item_last = cur.last && ({1'b0, k} == 3'(cur.count - 3'd1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      k <= '0;
      result.valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        k <= '0;
      end else if (finish) begin
        cur_valid <= 1'b0;
        k <= '0;
      end else if (step) begin
        k <= 2'(k + 2'd1);
      end
      if (step) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
    if (step) begin
      result.out_byte <= item_byte;
      result.last_out <= item_last;
      result.error <= item_err;
    end
  end

`ifndef SYNTH
  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> ({1'b0, k} < cur.count))
    else $error("item index beyond job length");

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.error) |-> (result.last_out && result.out_byte == 8'h00))
    else $error("error item not final or not zero");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!result.valid && !cur_valid))
    else $error("back busy after reset");

  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!cur_valid || finish))
    else $error("job loaded over a running job");
`endif

endmodule

// ===== hdl/base64_stream_codec_top.sv =====
// path: a group's job goes from the front into the job queue, from the queue into the expander,
// and from the expander into the output register
// throughput: one input item per cycle while the job queue is not full; one result item per
// cycle while the receiver is ready, set by the single output register
// reset: synchronous, active high; encode with standard alphabet, empty queue, no results
// ----------------------------------------------------------------------------
// base64_stream_codec_top
// streaming base64 encoder and decoder with a decoupled job queue
// ----------------------------------------------------------------------------
module base64_stream_codec_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [b64_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [b64_pkg::CFG_DATA_W-1:0] cfg_data,
  b64_in_if.sink                         stream,
  b64_out_if.source                      result
);

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_not_empty;
  logic          url_alphabet;
  b64_pkg::job_t push_job;
  b64_pkg::job_t q_head;

  b64_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .stream       (stream),
    .q_full       (q_full),
    .push         (push),
    .job          (push_job),
    .url_alphabet (url_alphabet)
  );

  b64_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  b64_back u_back (
    .clk          (clk),
    .rst          (rst),
    .url_alphabet (url_alphabet),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .pop          (pop),
    .result       (result)
  );

endmodule

// ===== verif/b64_codec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_codec_checker
// watches the config port and both item channels of the base64 codec, keeps
// its own encoder and decoder state, queues the characters or bytes each
// accepted item should produce and compares every result item against them
// ----------------------------------------------------------------------------
module b64_codec_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [b64_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [b64_pkg::CFG_DATA_W-1:0] cfg_data,
  b64_in_if                              stream,
  b64_out_if                             result,
  output int                             fails,
  output int                             outstanding,
  output int                             results_seen,
  output int                             error_results
);

  localparam logic [0:63][7:0] STD_ALPHA =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [0:63][7:0] URL_ALPHA =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } codec_out_t;

  codec_out_t  codec_out_q[$];

  logic        dir;
  logic        url;
  logic [17:0] grp_bits;
  logic [1:0]  grp_pos;
  logic [1:0]  pads;
  logic        bad;

  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    for (int s = 0; s < 64; s++) begin
      if (STD_ALPHA[s] == c || URL_ALPHA[s] == c) return 7'(s);
    end
    return 7'd64;
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] s, input logic use_url);
    return use_url ? URL_ALPHA[s] : STD_ALPHA[s];
  endfunction

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    fails++;
  endtask

  task automatic clear_group();
    grp_bits = '0;
    grp_pos = '0;
    pads = '0;
    bad = 1'b0;
  endtask

  task automatic push_out(input logic [7:0] d, input logic l, input logic e);
    codec_out_q.push_back('{data: d, last: l, err: e});
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic last);
    logic [23:0] trip;
    int          n;
    if (grp_pos < 2 && !last) begin
      grp_bits = {grp_bits[9:0], b};
      grp_pos++;
    end else begin
      if (grp_pos >= 2) begin
        trip = {grp_bits[15:0], b};
        n = 4;
      end else if (grp_pos == 1) begin
        trip = {grp_bits[7:0], b, 8'h00};
        n = 3;
      end else begin
        trip = {b, 16'h0000};
        n = 2;
      end
      for (int k = 0; k < 4; k++) begin
        if (k < n) push_out(sextet_char(trip[23-6*k -: 6], url), k == 3 && last, 1'b0);
        else push_out(b64_pkg::CH_PAD, k == 3 && last, 1'b0);
      end
      clear_group();
    end
  endtask

  task automatic decode_char(input logic [7:0] c, input logic last);
    logic [6:0]  v;
    logic [23:0] trip;
    int          n;
    v = char_sextet(c);
    if (!bad) begin
      if (c == b64_pkg::CH_PAD) begin
        if (grp_pos < 2) bad = 1'b1;
        else begin
          pads = pads + 2'd1;
          v = '0;
        end
      end else if (v[6] || pads != 0) begin
        bad = 1'b1;
      end
    end
    if (bad) begin
      if (last) begin
        push_out(8'h00, 1'b1, 1'b1);
        clear_group();
      end
    end else if (grp_pos < 3) begin
      grp_bits = {grp_bits[11:0], v[5:0]};
      grp_pos++;
      if (last) begin
        push_out(8'h00, 1'b1, 1'b1);
        clear_group();
      end
    end else begin
      trip = {grp_bits, v[5:0]};
      if (pads != 0 && !last) begin
        // padded group followed by more text
        grp_bits = '0;
        grp_pos = '0;
        pads = '0;
        bad = 1'b1;
      end else begin
        n = 3 - int'(pads);
        for (int k = 0; k < n; k++) push_out(trip[23-8*k -: 8], k == n - 1 && last, 1'b0);
        clear_group();
      end
    end
  endtask

  always @(posedge clk) begin
    codec_out_t got;
    codec_out_t want;
    if (rst) begin
      dir = b64_pkg::DIR_ENCODE;
      url = 1'b0;
      clear_group();
      codec_out_q.delete();
      fails = 0;
      results_seen = 0;
      error_results = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == b64_pkg::REG_DIRECTION) begin
          dir = cfg_data[0];
          clear_group();
        end else if (cfg_index == b64_pkg::REG_URL_ALPHABET) begin
          url = cfg_data[0];
        end
      end
      if (stream.valid && stream.ready) begin
        if (dir == b64_pkg::DIR_ENCODE) encode_byte(stream.in_byte, stream.last_in);
        else decode_char(stream.in_byte, stream.last_in);
      end
      if (result.valid && result.ready) begin
        got = '{data: result.out_byte, last: result.last_out, err: result.error};
        results_seen++;
        if (got.err) error_results++;
        if (codec_out_q.size() == 0) begin
          report($sformatf("result 0x%02h last %0b error %0b with nothing expected",
                           got.data, got.last, got.err));
        end else begin
          want = codec_out_q.pop_front();
          if (got.data !== want.data)
            report($sformatf("out_byte 0x%02h, expected 0x%02h", got.data, want.data));
          if (got.last !== want.last)
            report($sformatf("last_out %0b, expected %0b", got.last, want.last));
          if (got.err !== want.err)
            report($sformatf("error %0b, expected %0b", got.err, want.err));
        end
      end
    end
    outstanding = codec_out_q.size();
  end

endmodule

// ===== verif/base64_stream_codec_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec_top_tb
// drives the base64 codec with directed and random messages in both
// directions and alphabets under several idle and stall patterns; a checker
// beside the block predicts and compares every result item
// ----------------------------------------------------------------------------
module base64_stream_codec_top_tb;

  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 12;
  localparam int BURST_ITEMS    = 20;
  localparam int BUSY_PCT       = 72;
  localparam int LIGHT_PCT      = 8;

  typedef enum int {
    FLAW_BAD_CHAR,
    FLAW_SHORT,
    FLAW_EARLY_PAD,
    FLAW_EXTRA_GROUP,
    FLAW_NOISE
  } flaw_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [b64_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [b64_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int fails;
  int outstanding;
  int results_seen;
  int error_results;

  logic [7:0] msg_q[$];

  b64_in_if  stream_ch ();
  b64_out_if result_ch ();

  always #5 clk = ~clk;

  base64_stream_codec_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .stream   (stream_ch),
    .result   (result_ch)
  );

  b64_codec_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .stream       (stream_ch),
    .result       (result_ch),
    .fails        (fails),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .error_results(error_results)
  );

  // receiver side
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        result_ch.ready = 1'b0;
        rx_hold--;
      end else begin
        result_ch.ready = $urandom_range(0, 99) >= rx_stall_pct;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", quiet_cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic l);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      stream_ch.valid = 1'b0;
      @(negedge clk);
    end
    stream_ch.valid = 1'b1;
    stream_ch.in_byte = b;
    stream_ch.last_in = l;
    @(posedge clk);
    while (!stream_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
  endtask

  task automatic send_msg(input bit close);
    foreach (msg_q[i]) send_item(msg_q[i], close && i == msg_q.size() - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    stream_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_reg(input logic [b64_pkg::CFG_IDX_W-1:0] idx,
                         input logic [b64_pkg::CFG_DATA_W-1:0] val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic fill_encode_msg();
    msg_q.delete();
    repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic fill_decode_msg();
    int    pad;
    int    pos;
    flaw_t flaw;
    msg_q.delete();
    repeat (4 * $urandom_range(1, 3))
      msg_q.push_back(b64_pkg::enc_char(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1))));
    pad = $urandom_range(0, 2);
    if (pad >= 1) msg_q[msg_q.size() - 1] = b64_pkg::CH_PAD;
    if (pad == 2) msg_q[msg_q.size() - 2] = b64_pkg::CH_PAD;
    if ($urandom_range(0, 3) == 0) begin
      flaw = flaw_t'($urandom_range(0, 4));
      pos = $urandom_range(0, msg_q.size() - 1);
      case (flaw)
        FLAW_BAD_CHAR: msg_q[pos] = 8'($urandom_range(0, 255));
        FLAW_SHORT: void'(msg_q.pop_back());
        FLAW_EARLY_PAD: msg_q[pos] = b64_pkg::CH_PAD;
        FLAW_EXTRA_GROUP: begin
          repeat (4)
            msg_q.push_back(b64_pkg::enc_char(6'($urandom_range(0, 63)),
                                              1'($urandom_range(0, 1))));
        end
        default: begin
          msg_q.delete();
          repeat ($urandom_range(1, 6)) msg_q.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  task automatic run_phase(input int tx, input int rx, input logic dir, input logic url,
                           input bit drain_midway);
    int target;
    int half;
    tx_idle_pct = tx;
    rx_stall_pct = rx;
    set_reg(b64_pkg::REG_DIRECTION, dir);
    set_reg(b64_pkg::REG_URL_ALPHABET, url);
    target = items_sent + PHASE_ITEMS;
    half = items_sent + PHASE_ITEMS / 2;
    while (items_sent < target) begin
      if (dir == b64_pkg::DIR_ENCODE) fill_encode_msg();
      else fill_decode_msg();
      send_msg(dir == b64_pkg::DIR_DECODE || $urandom_range(0, 7) != 0);
      if (drain_midway && items_sent >= half) begin
        wait_drained();
        drain_midway = 1'b0;
      end
    end
  endtask

  initial begin
    stream_ch.valid = 1'b0;
    stream_ch.in_byte = 8'h00;
    stream_ch.last_in = 1'b0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // encode, standard alphabet from reset: full group, one and two byte tails; then a full group, URL alphabet
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFB, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'hFB, 1'b0);
    send_item(8'hFF, 1'b1);
    set_reg(b64_pkg::REG_URL_ALPHABET, 1'b1);
    send_item(8'hFB, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFE, 1'b1);

    // decode: both alphabets, padding, early pad, bad char, short message
    set_reg(b64_pkg::REG_DIRECTION, b64_pkg::DIR_DECODE);
    send_text("-_+/");
    send_text("QUI=");
    send_text("QQ==");
    send_text("=");
    send_text("*");
    send_text("Q");

    run_phase(0, 0, b64_pkg::DIR_ENCODE, 1'b0, 1'b0);
    run_phase(BUSY_PCT, 0, b64_pkg::DIR_DECODE, 1'b0, 1'b1);
    run_phase(0, BUSY_PCT, b64_pkg::DIR_ENCODE, 1'b1, 1'b0);
    run_phase(LIGHT_PCT, LIGHT_PCT, b64_pkg::DIR_DECODE, 1'b1, 1'b0);

    // long receiver hold while the sender keeps pushing
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    set_reg(b64_pkg::REG_DIRECTION, b64_pkg::DIR_ENCODE);
    set_reg(b64_pkg::REG_URL_ALPHABET, 1'b0);
    rx_hold = HOLD_CYCLES;
    for (int i = 0; i < BURST_ITEMS; i++)
      send_item(8'($urandom_range(0, 255)), i == BURST_ITEMS - 1);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("summary: %0d items in, %0d results out, %0d of them decode errors",
             items_sent, results_seen, error_results);
    $display("summary: encode and decode, both alphabets, idle on either side, hold and drain");
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
